// ----- rtl/core/hsl_to_rgb_converter_top_macros.svh -----
// Assertion macros shared by the HSL to RGB converter RTL.
`ifndef HSL_TO_RGB_CONVERTER_TOP_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define H2R_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequence holds in the same cycle as its trigger.
`define H2R_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/core/hsl2rgb_pkg.sv -----
// Package with payload types, sector codes and constants of the HSL to RGB converter.
`default_nettype none

package hsl2rgb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 17;   // component width, Q1.FRAC_BITS

  localparam logic [CW-1:0] ONE        = CW'(1 << FRAC_BITS);
  localparam logic [15:0]   HUE_SECTOR = 16'd7680;    // 60 degrees
  localparam logic [15:0]   HUE_MAX    = 16'd46080;   // 360 degrees

  // 7680 = 512 * 15: shift by 9, then multiply by the reciprocal of 15.
  localparam int             SECTOR_SHIFT = 9;
  localparam int             RECIP_SHIFT  = 28;
  localparam logic [24:0]    RECIP_15     = 25'd17895698;  // ceil(2^28 / 15)

  typedef enum logic [2:0] {
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5,
    SECTOR_6 = 3'd6
  } sector_t;

  typedef struct packed {
    logic [15:0]   hue;
    logic [CW-1:0] saturation;
    logic [CW-1:0] lightness;
  } hsl_t;

  typedef struct packed {
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
  } rgb_t;

endpackage

`default_nettype wire

// ----- rtl/core/hsl_to_rgb_converter_top.sv -----
// HSL to RGB color converter: five-stage pipeline, one color per clock while the receiver does not stall.
// Usage:
//   hsl channel (hsl_valid, hsl_stall, hsl): one HSL color per transfer. Hue is
//   degrees times 128 (values above 360 degrees saturate), saturation and
//   lightness are Q1.16 and saturate at 1.0.
//   rgb channel (rgb_valid, rgb_stall, rgb): one RGB triple per transfer, Q1.16,
//   each component clamped to 1.0, in the order the colors came in.
// Throughput is one color per clock while rgb_stall is low; a transfer can
// happen on both channels in the same cycle.
// Stages: 1 clamp inputs, fold the hue and pick the sector; 2 chroma multiply;
// 3 chroma times hue position, offset L - C/2; 4 divide by one sector through
// a reciprocal multiply; 5 place C and X, add the offset, clamp. Each stage
// holds at most one multiplier.
// Reset (rst, synchronous, active high) empties the pipeline: all stage
// valid bits clear, data registers are left as they are.
// When the receiver stalls, the last stage holds its result and earlier
// stages keep advancing into empty slots; hsl_stall rises only once every
// stage holds a color, so nothing is lost or repeated.
`default_nettype none

module hsl_to_rgb_converter_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              hsl_valid,
  output logic                   hsl_stall,
  input  wire hsl2rgb_pkg::hsl_t hsl,
  output logic                   rgb_valid,
  input  wire logic              rgb_stall,
  output hsl2rgb_pkg::rgb_t      rgb
);
  import hsl2rgb_pkg::*;

  `include "hsl_to_rgb_converter_top_macros.svh"

  // Stage valid bits and per-stage load enables.
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic s1_en, s2_en, s3_en, s4_en, s5_en;

  // A stage loads when it is empty or the stage after it loads.
  assign s5_en = !s5_valid || !rgb_stall;
  assign s4_en = !s4_valid || s5_en;
  assign s3_en = !s3_valid || s4_en;
  assign s2_en = !s2_valid || s3_en;
  assign s1_en = !s1_valid || s2_en;

  assign hsl_stall = !s1_en;

  // ---------------------------------------------------------------- stage 1
  logic [15:0]   h_sat;
  logic [CW-1:0] s_sat, l_sat;
  logic [CW:0]   two_l;
  logic [CW:0]   l_dist;
  logic [13:0]   hue_rem;
  logic [12:0]   tri_dist;
  logic [12:0]   pos_in;
  sector_t       sector_in;

  always_comb begin
    h_sat = (hsl.hue > HUE_MAX) ? HUE_MAX : hsl.hue;
    s_sat = (hsl.saturation > ONE) ? ONE : hsl.saturation;
    l_sat = (hsl.lightness > ONE) ? ONE : hsl.lightness;

    // Distance of 2L from 1.0; never above 1.0 since L is clamped.
    two_l  = {l_sat, 1'b0};
    l_dist = (two_l >= {1'b0, ONE}) ? (two_l - {1'b0, ONE}) : ({1'b0, ONE} - two_l);

    // Hue modulo 120 degrees, then folded into a triangle around 60 degrees.
    if (h_sat >= 16'(6 * 7680)) begin
      hue_rem = 14'd0;
    end else if (h_sat >= 16'(4 * 7680)) begin
      hue_rem = 14'(h_sat - 16'(4 * 7680));
    end else if (h_sat >= 16'(2 * 7680)) begin
      hue_rem = 14'(h_sat - 16'(2 * 7680));
    end else begin
      hue_rem = 14'(h_sat);
    end
    tri_dist = (hue_rem >= 14'(HUE_SECTOR)) ? 13'(hue_rem - 14'(HUE_SECTOR))
                                            : 13'(14'(HUE_SECTOR) - hue_rem);
    pos_in   = 13'(HUE_SECTOR) - tri_dist;

    // Ceiling sector; hue zero goes to sector one.
    if (h_sat <= 16'(1 * 7680)) begin
      sector_in = SECTOR_1;
    end else if (h_sat <= 16'(2 * 7680)) begin
      sector_in = SECTOR_2;
    end else if (h_sat <= 16'(3 * 7680)) begin
      sector_in = SECTOR_3;
    end else if (h_sat <= 16'(4 * 7680)) begin
      sector_in = SECTOR_4;
    end else if (h_sat <= 16'(5 * 7680)) begin
      sector_in = SECTOR_5;
    end else begin
      sector_in = SECTOR_6;
    end
  end

  logic [CW-1:0] s1_omd, s1_sat, s1_light;
  logic [12:0]   s1_pos;
  sector_t       s1_sector;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= hsl_valid;
    end
    if (s1_en) begin
      s1_omd    <= ONE - l_dist[CW-1:0];
      s1_sat    <= s_sat;
      s1_light  <= l_sat;
      s1_pos    <= pos_in;
      s1_sector <= sector_in;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [2*CW-1:0] chroma_prod;
  assign chroma_prod = s1_omd * s1_sat;

  logic [CW-1:0] s2_c, s2_light;
  logic [12:0]   s2_pos;
  sector_t       s2_sector;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid;
    end
    if (s2_en) begin
      s2_c      <= chroma_prod[FRAC_BITS +: CW];
      s2_light  <= s1_light;
      s2_pos    <= s1_pos;
      s2_sector <= s1_sector;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [CW+12:0] cx_prod;
  logic [CW-1:0]  half_c;
  assign cx_prod = s2_c * s2_pos;
  assign half_c  = s2_c >> 1;

  logic [19:0]   s3_cx;   // chroma * position / 512, below 2^20
  logic [CW-1:0] s3_c, s3_m;
  sector_t       s3_sector;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_en) begin
      s3_valid <= s2_valid;
    end
    if (s3_en) begin
      s3_cx     <= cx_prod[SECTOR_SHIFT +: 20];
      s3_c      <= s2_c;
      s3_m      <= (s2_light >= half_c) ? (s2_light - half_c) : '0;
      s3_sector <= s2_sector;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Exact floor division by 15 for every value below 2^20.
  logic [44:0] recip_prod;
  assign recip_prod = s3_cx * RECIP_15;

  logic [CW-1:0] s4_x, s4_c, s4_m;
  sector_t       s4_sector;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_en) begin
      s4_valid <= s3_valid;
    end
    if (s4_en) begin
      s4_x      <= recip_prod[RECIP_SHIFT +: CW];
      s4_c      <= s3_c;
      s4_m      <= s3_m;
      s4_sector <= s3_sector;
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic [CW-1:0] r_pre, g_pre, b_pre;
  logic [CW:0]   r_sum, g_sum, b_sum;

  always_comb begin
    case (s4_sector)
      SECTOR_1: begin r_pre = s4_c; g_pre = s4_x; b_pre = '0;   end
      SECTOR_2: begin r_pre = s4_x; g_pre = s4_c; b_pre = '0;   end
      SECTOR_3: begin r_pre = '0;   g_pre = s4_c; b_pre = s4_x; end
      SECTOR_4: begin r_pre = '0;   g_pre = s4_x; b_pre = s4_c; end
      SECTOR_5: begin r_pre = s4_x; g_pre = '0;   b_pre = s4_c; end
      default:  begin r_pre = s4_c; g_pre = '0;   b_pre = s4_x; end
    endcase
    r_sum = {1'b0, r_pre} + {1'b0, s4_m};
    g_sum = {1'b0, g_pre} + {1'b0, s4_m};
    b_sum = {1'b0, b_pre} + {1'b0, s4_m};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (s5_en) begin
      s5_valid <= s4_valid;
    end
    if (s5_en) begin
      rgb.red   <= (r_sum > {1'b0, ONE}) ? ONE : r_sum[CW-1:0];
      rgb.green <= (g_sum > {1'b0, ONE}) ? ONE : g_sum[CW-1:0];
      rgb.blue  <= (b_sum > {1'b0, ONE}) ? ONE : b_sum[CW-1:0];
    end
  end

  assign rgb_valid = s5_valid;

  // ------------------------------------------------------------- assertions
  `H2R_ASSERT_IMPLY(a_rgb_range, rgb_valid,
                    (rgb.red <= ONE) && (rgb.green <= ONE) && (rgb.blue <= ONE),
                    "rgb component above one")
  `H2R_ASSERT_IMPLY(a_stall_only_full, hsl_stall,
                    s1_valid && s2_valid && s3_valid && s4_valid && s5_valid,
                    "input stalled with an empty stage")
  `H2R_ASSERT_IMPLY(a_x_not_above_c, s4_valid, s4_x <= s4_c,
                    "secondary component exceeds chroma")

endmodule

`default_nettype wire
